>>> rtl/lc3x_pkg.sv
// Shared constants, types and helper functions of the LC-3 subset execution block.
package lc3x_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int RF_DEPTH  = 8;
  localparam int RF_AW     = $clog2(RF_DEPTH);

  localparam logic [15:0] ORIGIN_RESET = 16'h3000;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_EXEC    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [1:0] CC_N = 2'd0;
  localparam logic [1:0] CC_Z = 2'd1;
  localparam logic [1:0] CC_P = 2'd2;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [15:0]      data;
  } rf_wr_t;

  function automatic logic [15:0] sext9(input logic [15:0] w);
    return {{7{w[8]}}, w[8:0]};
  endfunction

  function automatic logic [15:0] sext5(input logic [15:0] w);
    return {{11{w[4]}}, w[4:0]};
  endfunction

  function automatic logic [1:0] cc_of(input logic [15:0] v);
    logic [1:0] c;
    if (v[15]) begin
      c = CC_N;
    end else if (v == 16'd0) begin
      c = CC_Z;
    end else begin
      c = CC_P;
    end
    return c;
  endfunction

endpackage

>>> rtl/lc3x_mem.sv
// Main word memory with one synchronous read port and one write port.
module lc3x_mem (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [lc3x_pkg::MEM_AW-1:0]  rd_addr,
  output logic [15:0]                  rd_data,
  input  lc3x_pkg::mem_wr_t            wr
);
  import lc3x_pkg::*;

  logic [15:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/lc3x_regfile.sv
// General register file with two registered read ports, one write port and clear on restart.
module lc3x_regfile (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       rd_en,
  input  logic [lc3x_pkg::RF_AW-1:0] rd_addr_a,
  input  logic [lc3x_pkg::RF_AW-1:0] rd_addr_b,
  output logic [15:0]                rd_data_a,
  output logic [15:0]                rd_data_b,
  input  lc3x_pkg::rf_wr_t           wr
);
  import lc3x_pkg::*;

  logic [15:0]         regs [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld;
  logic [15:0]         word_a;
  logic [15:0]         word_b;
  logic                vld_a;
  logic                vld_b;

  // An entry that has not been written since restart reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (clear) begin
        vld <= '0;
      end
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      word_a <= regs[rd_addr_a];
      word_b <= regs[rd_addr_b];
      vld_a  <= vld[rd_addr_a];
      vld_b  <= vld[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a ? word_a : 16'd0;
  assign rd_data_b = vld_b ? word_b : 16'd0;

endmodule

>>> rtl/lc3_subset_execute_step.sv
// Top level: LC-3 subset processor with item sequencer, memories and result register.
// Sequence: a write, restart, ignored or halted execute item gives its result from the fetch state,
// an execute item from the operand state after the fetch, and an LDI from the indirect state (fetch,
// pointer, data reads).
// Throughput: a new item is taken in the cycle its predecessor completes, so writes run at one
// per cycle when the output is not held, while an execute item runs through its states first.
// Reset is synchronous: PC goes to 0x3000, registers read as zero, CC is Z and halt is clear.
module lc3_subset_execute_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address[15:0], data[31:16]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // next_pc, instr_word, cond_code, dest_index, dest_value,
                                 // dest_written, halted, zero pad
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);
  import lc3x_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_OPER  = 4'b0100,
    ST_IND   = 4'b1000
  } state_t;

  typedef struct packed {
    logic        pad;
    logic        halted;
    logic        dest_written;
    logic [15:0] dest_value;
    logic [2:0]  dest_index;
    logic [1:0]  cond_code;
    logic [15:0] instr_word;
    logic [15:0] next_pc;
  } res_t;

  state_t      state;
  logic [1:0]  kind_q;
  logic [15:0] origin;
  logic [15:0] pc;
  logic [15:0] ir;
  logic [15:0] ea;
  logic [1:0]  cc;
  logic        halt;

  logic        accept;
  logic        out_free;
  logic        fin;
  logic        done;
  logic        go_ind;
  logic        advance;
  logic        wrote;
  logic        restart;
  logic [15:0] val;
  logic [15:0] pc_calc;
  logic [15:0] pc_next;
  logic [1:0]  cc_calc;
  logic        halt_calc;
  logic [15:0] ea_calc;
  logic [15:0] opnd;
  logic [3:0]  op;
  res_t        res;

  logic              mem_rd_en;
  logic [MEM_AW-1:0] mem_rd_addr;
  logic [15:0]       mem_rd_data;
  mem_wr_t           mem_wr;
  rf_wr_t            rf_wr;
  logic [15:0]       rf_a;
  logic [15:0]       rf_b;

  assign op      = ir[15:12];
  assign ea_calc = pc + 16'd1 + sext9(mem_rd_data);
  assign opnd    = ir[5] ? sext5(ir) : rf_b;

  always_comb begin
    fin       = 1'b0;
    go_ind    = 1'b0;
    wrote     = 1'b0;
    restart   = 1'b0;
    val       = 16'd0;
    pc_calc   = pc;
    halt_calc = halt;
    unique case (state)
      ST_IDLE: begin
      end
      ST_FETCH: begin
        if (kind_q != KIND_EXEC || halt) begin
          fin = 1'b1;
          if (kind_q == KIND_RESTART) begin
            restart   = 1'b1;
            pc_calc   = origin;
            halt_calc = 1'b0;
          end
        end
      end
      ST_OPER: begin
        fin = 1'b1;
        unique case (op)
          OP_ADD: begin
            wrote = 1'b1;
            val   = rf_a + opnd;
          end
          OP_AND: begin
            wrote = 1'b1;
            val   = rf_a & opnd;
          end
          OP_NOT: begin
            wrote = 1'b1;
            val   = ~rf_a;
          end
          OP_LD: begin
            wrote = 1'b1;
            val   = mem_rd_data;
          end
          OP_LDI: begin
            fin    = 1'b0;
            go_ind = 1'b1;
          end
          OP_LEA: begin
            wrote = 1'b1;
            val   = ea;
          end
          OP_BR: begin
            if ((ir[11] && cc == CC_N) || (ir[10] && cc == CC_Z) ||
                (ir[9] && cc == CC_P)) begin
              pc_calc = ea;
            end
          end
          OP_TRAP: begin
            halt_calc = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_IND: begin
        fin   = 1'b1;
        wrote = 1'b1;
        val   = mem_rd_data;
      end
      default: begin
      end
    endcase
    if (restart) begin
      cc_calc = CC_Z;
    end else if (wrote) begin
      cc_calc = cc_of(val);
    end else begin
      cc_calc = cc;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign done     = fin && out_free;
  assign s_tready = (state == ST_IDLE) || done;
  assign accept   = s_tvalid && s_tready;
  assign advance  = (state == ST_FETCH) && !fin;
  assign pc_next  = done ? pc_calc : pc;

  // The fetch of a newly taken item uses the PC that the finishing item leaves behind.
  assign mem_rd_en = accept || advance || go_ind;
  always_comb begin
    if (accept) begin
      mem_rd_addr = pc_next[MEM_AW-1:0];
    end else if (state == ST_FETCH) begin
      mem_rd_addr = ea_calc[MEM_AW-1:0];
    end else begin
      mem_rd_addr = mem_rd_data[MEM_AW-1:0];
    end
  end

  assign mem_wr.en   = accept && (s_tuser == KIND_WRITE);
  assign mem_wr.addr = s_tdata[MEM_AW-1:0];
  assign mem_wr.data = s_tdata[31:16];

  assign rf_wr.en   = done && wrote;
  assign rf_wr.addr = ir[11:9];
  assign rf_wr.data = val;

  lc3x_mem u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr      (mem_wr)
  );

  lc3x_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .clear     (done && restart),
    .rd_en     (advance),
    .rd_addr_a (mem_rd_data[8:6]),
    .rd_addr_b (mem_rd_data[2:0]),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr        (rf_wr)
  );

  always_comb begin
    res              = '0;
    res.next_pc      = pc_calc;
    res.instr_word   = ir;
    res.cond_code    = cc_calc;
    res.dest_index   = wrote ? ir[11:9] : 3'd0;
    res.dest_value   = val;
    res.dest_written = wrote;
    res.halted       = halt_calc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      origin   <= ORIGIN_RESET;
      pc       <= ORIGIN_RESET;
      ir       <= 16'd0;
      cc       <= CC_Z;
      halt     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        origin <= cfg_wdata;
      end
      if (done) begin
        m_tvalid <= 1'b1;
        pc       <= pc_calc;
        cc       <= cc_calc;
        halt     <= halt_calc;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance) begin
        pc <= pc + 16'd1;
        ir <= mem_rd_data;
      end
      if (accept) begin
        state <= ST_FETCH;
      end else if (done) begin
        state <= ST_IDLE;
      end else if (advance) begin
        state <= ST_OPER;
      end else if (go_ind) begin
        state <= ST_IND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= s_tuser;
    end
    if (advance) begin
      ea <= ea_calc;
    end
    if (done) begin
      m_tdata <= res;
    end
  end

endmodule

>>> bench/lc3_subset_execute_step_tb.sv
// Self-checking stream testbench for the LC-3 subset execution block.
`timescale 1ns / 100ps

module lc3_subset_execute_step_tb;
  import lc3x_pkg::*;

  localparam logic [1:0] KIND_IGNORED  = 2'd3;
  localparam logic [3:0] OP_UNUSED     = 4'hD;
  localparam int         STALL_LIMIT   = 1000;
  localparam int         HOLD_CYCLES   = 80;
  localparam int         SETTLE_CYCLES = 10;

  typedef struct packed {
    logic        halted;
    logic        dest_written;
    logic [15:0] dest_value;
    logic [2:0]  dest_index;
    logic [1:0]  cond_code;
    logic [15:0] instr_word;
    logic [15:0] next_pc;
  } step_result_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [15:0]  addr;
    logic [15:0]  data;
    step_result_t outcome;
  } cpu_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Architectural state as the bench expects it to evolve.
  logic [15:0] start_addr;
  logic [15:0] prog_pc;
  logic [15:0] cpu_ir;
  logic [1:0]  cpu_cc;
  logic        cpu_halted;
  logic [15:0] gpr [8];
  logic [15:0] mem_image [MEM_WORDS];
  bit          mem_filled [MEM_WORDS];

  cpu_item_t    item_queue [$];
  step_result_t expected_results [$];
  cpu_item_t    offered;
  step_result_t want, got;
  logic         s_taken = 1'b0;
  int           items_outstanding = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_requests = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  lc3_subset_execute_step u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int unsigned mem_slot(logic [15:0] a);
    return a % MEM_WORDS;
  endfunction

  function automatic step_result_t predict_step(logic [1:0] kind, logic [15:0] addr,
                                                logic [15:0] wdata);
    step_result_t r;
    logic [15:0]  word, offset, opnd, ptr, val;
    logic [2:0]   dr;
    logic         wrote, take;
    wrote = 1'b0;
    dr = '0;
    val = '0;
    if (kind == KIND_WRITE) begin
      mem_image[mem_slot(addr)] = wdata;
      mem_filled[mem_slot(addr)] = 1'b1;
    end else if (kind == KIND_RESTART) begin
      prog_pc = start_addr;
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      cpu_cc = CC_Z;
      cpu_halted = 1'b0;
    end else if (kind == KIND_EXEC && !cpu_halted) begin
      word = mem_image[mem_slot(prog_pc)];
      cpu_ir = word;
      prog_pc = prog_pc + 16'd1;
      offset = {{7{word[8]}}, word[8:0]};
      dr = word[11:9];
      case (word[15:12])
        OP_ADD, OP_AND: begin
          opnd = word[5] ? {{11{word[4]}}, word[4:0]} : gpr[word[2:0]];
          val = (word[15:12] == OP_ADD) ? gpr[word[8:6]] + opnd : gpr[word[8:6]] & opnd;
          wrote = 1'b1;
        end
        OP_NOT: begin
          val = ~gpr[word[8:6]];
          wrote = 1'b1;
        end
        OP_LD: begin
          val = mem_image[mem_slot(prog_pc + offset)];
          wrote = 1'b1;
        end
        OP_LDI: begin
          ptr = mem_image[mem_slot(prog_pc + offset)];
          val = mem_image[mem_slot(ptr)];
          wrote = 1'b1;
        end
        OP_LEA: begin
          val = prog_pc + offset;
          wrote = 1'b1;
        end
        OP_BR: begin
          take = (word[11] && cpu_cc == CC_N) || (word[10] && cpu_cc == CC_Z) ||
                 (word[9] && cpu_cc == CC_P);
          if (take) prog_pc = prog_pc + offset;
        end
        OP_TRAP: begin
          cpu_halted = 1'b1;
        end
        default: begin
        end
      endcase
      if (wrote) begin
        gpr[dr] = val;
        cpu_cc = val[15] ? CC_N : ((val == 16'd0) ? CC_Z : CC_P);
      end
    end
    if (!wrote) begin
      dr = '0;
      val = '0;
    end
    r.next_pc = prog_pc;
    r.instr_word = cpu_ir;
    r.cond_code = cpu_cc;
    r.dest_index = dr;
    r.dest_value = val;
    r.dest_written = wrote;
    r.halted = cpu_halted;
    return r;
  endfunction

  task automatic queue_item(logic [1:0] kind, logic [15:0] addr, logic [15:0] data);
    step_result_t r;
    r = predict_step(kind, addr, data);
    item_queue.push_back(cpu_item_t'{kind: kind, addr: addr, data: data, outcome: r});
    items_outstanding++;
  endtask

  // Same memory slot, random upper address bits.
  function automatic logic [15:0] alias_addr(logic [15:0] a);
    return (16'($urandom) & ~16'(MEM_WORDS - 1)) | (a & 16'(MEM_WORDS - 1));
  endfunction

  function automatic logic [15:0] random_instr();
    logic [3:0]  op;
    logic [11:0] body;
    int          pick;
    pick = $urandom_range(0, 99);
    body = 12'($urandom);
    if (pick < 20) op = OP_ADD;
    else if (pick < 35) op = OP_AND;
    else if (pick < 43) op = OP_NOT;
    else if (pick < 53) op = OP_LD;
    else if (pick < 61) op = OP_LDI;
    else if (pick < 69) op = OP_LEA;
    else if (pick < 85) op = OP_BR;
    else if (pick < 88) op = OP_TRAP;
    else op = 4'($urandom);
    if ((op == OP_BR || op == OP_LD || op == OP_LDI || op == OP_LEA) &&
        $urandom_range(0, 1) == 1) begin
      body[8:0] = 9'($urandom_range(0, 15)) - 9'd8;
    end
    return {op, body};
  endfunction

  // Every word that an execute will read is written beforehand.
  task automatic queue_exec();
    logic [15:0] word, target, ptr;
    if (!cpu_halted) begin
      if (!mem_filled[mem_slot(prog_pc)]) begin
        queue_item(KIND_WRITE, alias_addr(prog_pc), random_instr());
      end
      word = mem_image[mem_slot(prog_pc)];
      target = prog_pc + 16'd1 + {{7{word[8]}}, word[8:0]};
      if ((word[15:12] == OP_LD || word[15:12] == OP_LDI) && !mem_filled[mem_slot(target)]) begin
        queue_item(KIND_WRITE, alias_addr(target), 16'($urandom));
      end
      if (word[15:12] == OP_LDI) begin
        ptr = mem_image[mem_slot(target)];
        if (!mem_filled[mem_slot(ptr)]) begin
          queue_item(KIND_WRITE, alias_addr(ptr), 16'($urandom));
        end
      end
    end
    queue_item(KIND_EXEC, 16'($urandom), 16'($urandom));
  endtask

  task automatic queue_program_run();
    int len, steps, pick;
    len = $urandom_range(4, 12);
    for (int i = 0; i < len; i++) queue_item(KIND_WRITE, start_addr + 16'(i), random_instr());
    queue_item(KIND_RESTART, 16'($urandom), 16'($urandom));
    steps = $urandom_range(8, 14);
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_item(KIND_WRITE, 16'($urandom), 16'($urandom));
      end else if (pick < 9) begin
        queue_item(KIND_IGNORED, 16'($urandom), 16'($urandom));
      end else if (pick < 11 || (cpu_halted && pick < 40)) begin
        queue_item(KIND_RESTART, 16'($urandom), 16'($urandom));
      end else begin
        queue_exec();
      end
    end
  endtask

  task automatic wait_drained();
    while (items_outstanding != 0) @(negedge clk);
  endtask

  task automatic write_origin(logic [15:0] value);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    start_addr = value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic flag_field(string name, logic [15:0] expected, logic [15:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (item_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        offered = item_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {offered.data, offered.addr};
        s_tuser <= offered.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    s_taken <= s_tvalid && s_tready;
    if (m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none outstanding, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        got = m_tdata[54:0];
        flag_field("next_pc", want.next_pc, got.next_pc);
        flag_field("instr_word", want.instr_word, got.instr_word);
        flag_field("cond_code", 16'(want.cond_code), 16'(got.cond_code));
        flag_field("dest_index", 16'(want.dest_index), 16'(got.dest_index));
        flag_field("dest_value", want.dest_value, got.dest_value);
        flag_field("dest_written", 16'(want.dest_written), 16'(got.dest_written));
        flag_field("halted", 16'(want.halted), 16'(got.halted));
        items_outstanding--;
      end
    end
    if (s_tvalid && s_tready) expected_results.push_back(offered.outcome);
    if (rst || items_outstanding == 0 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("lc3_subset_execute_step regression: fail");
      $finish;
    end
  end

  initial begin
    start_addr = ORIGIN_RESET;
    prog_pc = ORIGIN_RESET;
    cpu_ir = '0;
    cpu_cc = CC_Z;
    cpu_halted = 1'b0;
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) mem_filled[i] = 1'b0;

    // A short program that touches every instruction, the sign-extension corners,
    // the 0x7FFF load, an untaken empty branch and a halt.
    queue_item(KIND_WRITE, 16'h3000, {OP_ADD, 3'd1, 3'd1, 1'b1, 5'h10});
    queue_item(KIND_WRITE, 16'h3001, {OP_AND, 3'd2, 3'd1, 1'b1, 5'h0F});
    queue_item(KIND_WRITE, 16'h3002, {OP_NOT, 3'd3, 3'd2, 6'h3F});
    queue_item(KIND_WRITE, 16'h3003, {OP_ADD, 3'd4, 3'd3, 1'b0, 2'b00, 3'd3});
    queue_item(KIND_WRITE, 16'h3004, {OP_LD, 3'd5, 9'd11});
    queue_item(KIND_WRITE, 16'h3005, {OP_LDI, 3'd6, 9'd11});
    queue_item(KIND_WRITE, 16'h3006, {OP_LEA, 3'd7, 9'h100});
    queue_item(KIND_WRITE, 16'h3007, {OP_BR, 3'b000, 9'h0FF});
    queue_item(KIND_WRITE, 16'h3008, {OP_BR, 3'b001, 9'h001});
    queue_item(KIND_WRITE, 16'h300A, {OP_UNUSED, 12'hFFF});
    queue_item(KIND_WRITE, 16'h300B, {OP_TRAP, 12'h025});
    queue_item(KIND_WRITE, 16'h3010, 16'h7FFF);
    queue_item(KIND_WRITE, 16'h3011, 16'hFC40);
    queue_item(KIND_WRITE, 16'hFC40, 16'h8001);
    for (int i = 0; i < 12; i++) queue_exec();
    queue_item(KIND_IGNORED, 16'hFFFF, 16'hFFFF);
    queue_item(KIND_RESTART, 16'h0000, 16'h0000);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      for (int run = 0; run < 5; run++) begin
        if (run == 0 || run == 3) begin
          wait_drained();
          if (run == 0) begin
            send_idle_pct = (mode == 0) ? 8 : ((mode == 1) ? 78 : 0);
            recv_idle_pct = (mode == 0) ? 78 : ((mode == 1) ? 8 : 0);
          end
          if (run == 0) begin
            write_origin((mode == 0) ? 16'h0000 : ((mode == 1) ? 16'hFFFF : 16'($urandom)));
          end else begin
            write_origin((mode == 2) ? ORIGIN_RESET : 16'($urandom));
          end
        end
        queue_program_run();
        if (mode == 0 && run == 2) hold_requests++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("lc3_subset_execute_step regression: pass");
    end else begin
      $display("lc3_subset_execute_step regression: fail");
    end
    $finish;
  end

endmodule
